>>> src/mrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus-RTU response receiver package
// Shared types, codes, constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // Largest data byte count accepted in a read response.
  localparam int unsigned MAX_DATA = 16;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  FUNC_WRITE = 8'h06;
  localparam logic [7:0]  ECHO_COUNT = 8'd6;

  localparam logic [7:0]  SLAVE_ADDRESS_RST   = 8'h20;
  localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd200;
  localparam logic [7:0]  EXPECTED_LENGTH_RST = 8'd8;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W  = 48;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_MODE       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LENGTH = 2'd3;

  // Input word kinds.
  localparam logic [1:0] MODE_ARM  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_COUNT_BIG = 3'd3,
    ST_CRC_BAD   = 3'd4,
    ST_LENGTH    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic        echo_mode;
    logic [15:0] timeout_ticks;
    logic [7:0]  expected_length;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  byte_count;
    logic [7:0]  first_value;
    logic [31:0] second_value;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic result_t make_result(input status_t st, input logic [7:0] count,
                                          input logic [7:0] first,
                                          input logic [31:0] second);
    result_t r;
    r.status       = st;
    r.byte_count   = count;
    r.first_value  = first;
    r.second_value = second;
    return r;
  endfunction

endpackage

>>> src/mrr_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus-RTU frame checker
// Walks one response frame a word at a time: header checks, CRC-16, data
// capture and the per-byte timeout. Gives at most one result per word.
// ----------------------------------------------------------------------------
module mrr_frame (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       mode,
  input  logic [7:0]       rx_byte,
  input  mrr_pkg::cfg_t    cfg,
  output logic             res_valid,
  output mrr_pkg::result_t res
);
  import mrr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEAD, PH_DATA, PH_RCRCLO, PH_RCRCHI, PH_ECHO, PH_ECRCLO, PH_ECRCHI
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  data_count, data_count_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic [7:0]  crc_low_hold, crc_low_hold_next;
  logic [7:0]  first_hold, first_hold_next;
  logic [31:0] second_hold, second_hold_next;
  logic [15:0] tick_count, tick_count_next;

  logic [15:0] crc_fed;
  logic [15:0] tick_inc;
  logic [7:0]  index_inc;
  logic        crc_match;

  assign crc_fed   = crc16_byte(crc_accum, rx_byte);
  assign tick_inc  = tick_count + 16'd1;
  assign index_inc = byte_index + 8'd1;
  // The trailing CRC arrives low byte first.
  assign crc_match = ({rx_byte, crc_low_hold} == crc_accum);

  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    data_count_next   = data_count;
    crc_accum_next    = crc_accum;
    crc_low_hold_next = crc_low_hold;
    first_hold_next   = first_hold;
    second_hold_next  = second_hold;
    tick_count_next   = tick_count;
    res_valid         = 1'b0;
    res               = make_result(ST_OK, 8'd0, 8'd0, 32'd0);

    if (in_valid) begin
      case (mode)
        MODE_ARM: begin
          byte_index_next   = 8'd0;
          data_count_next   = 8'd0;
          crc_accum_next    = CRC_INIT;
          crc_low_hold_next = 8'd0;
          first_hold_next   = 8'd0;
          second_hold_next  = 32'd0;
          tick_count_next   = 16'd0;
          if (cfg.echo_mode) begin
            phase_next      = PH_ECHO;
            data_count_next = ECHO_COUNT;
          end else begin
            phase_next = PH_HEAD;
          end
        end
        MODE_TICK: begin
          if (phase != PH_IDLE) begin
            tick_count_next = tick_inc;
            if (tick_inc >= cfg.timeout_ticks) begin
              res_valid  = 1'b1;
              res        = make_result(ST_TIMEOUT, data_count, 8'd0, 32'd0);
              phase_next = PH_IDLE;
            end
          end
        end
        MODE_BYTE: begin
          if (phase != PH_IDLE) begin
            tick_count_next = 16'd0;
            case (phase)
              PH_HEAD: begin
                if ((byte_index == 8'd0 && rx_byte != cfg.slave_address) ||
                    (byte_index == 8'd1 && rx_byte != FUNC_READ)) begin
                  res_valid  = 1'b1;
                  res        = make_result(ST_BAD_HDR, 8'd0, 8'd0, 32'd0);
                  phase_next = PH_IDLE;
                end else begin
                  crc_accum_next = crc_fed;
                  if (byte_index == 8'd2) begin
                    data_count_next = rx_byte;
                    if (rx_byte > 8'(MAX_DATA)) begin
                      res_valid  = 1'b1;
                      res        = make_result(ST_COUNT_BIG, rx_byte, 8'd0, 32'd0);
                      phase_next = PH_IDLE;
                    end else begin
                      byte_index_next = 8'd0;
                      phase_next      = (rx_byte == 8'd0) ? PH_RCRCLO : PH_DATA;
                    end
                  end else begin
                    byte_index_next = index_inc;
                  end
                end
              end
              PH_DATA: begin
                crc_accum_next = crc_fed;
                case (byte_index)
                  8'd0: first_hold_next = rx_byte;
                  8'd2: second_hold_next[31:24] = rx_byte;
                  8'd3: second_hold_next[23:16] = rx_byte;
                  8'd4: second_hold_next[15:8]  = rx_byte;
                  8'd5: second_hold_next[7:0]   = rx_byte;
                  default: ;
                endcase
                byte_index_next = index_inc;
                if (index_inc >= data_count) begin
                  phase_next = PH_RCRCLO;
                end
              end
              PH_ECHO: begin
                if ((byte_index == 8'd0 && rx_byte != cfg.slave_address) ||
                    (byte_index == 8'd1 && rx_byte != FUNC_WRITE)) begin
                  res_valid  = 1'b1;
                  res        = make_result(ST_BAD_HDR, data_count, 8'd0, 32'd0);
                  phase_next = PH_IDLE;
                end else begin
                  crc_accum_next  = crc_fed;
                  byte_index_next = index_inc;
                  if (index_inc >= ECHO_COUNT) begin
                    phase_next = PH_ECRCLO;
                  end
                end
              end
              PH_RCRCLO: begin
                crc_low_hold_next = rx_byte;
                phase_next        = PH_RCRCHI;
              end
              PH_ECRCLO: begin
                crc_low_hold_next = rx_byte;
                phase_next        = PH_ECRCHI;
              end
              PH_RCRCHI: begin
                res_valid  = 1'b1;
                phase_next = PH_IDLE;
                if (!crc_match) begin
                  res = make_result(ST_CRC_BAD, data_count, 8'd0, 32'd0);
                end else if (data_count != cfg.expected_length) begin
                  res = make_result(ST_LENGTH, data_count, 8'd0, 32'd0);
                end else begin
                  res = make_result(ST_OK, data_count, first_hold, second_hold);
                end
              end
              PH_ECRCHI: begin
                res_valid  = 1'b1;
                phase_next = PH_IDLE;
                res = make_result(crc_match ? ST_OK : ST_CRC_BAD, data_count, 8'd0, 32'd0);
              end
              default: phase_next = PH_IDLE;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_index   <= 8'd0;
      data_count   <= 8'd0;
      crc_accum    <= CRC_INIT;
      crc_low_hold <= 8'd0;
      first_hold   <= 8'd0;
      second_hold  <= 32'd0;
      tick_count   <= 16'd0;
    end else begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      data_count   <= data_count_next;
      crc_accum    <= crc_accum_next;
      crc_low_hold <= crc_low_hold_next;
      first_hold   <= first_hold_next;
      second_hold  <= second_hold_next;
      tick_count   <= tick_count_next;
    end
  end

  a_result_needs_word: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_valid)
    else $error("result raised without an accepted word");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> phase == PH_IDLE)
    else $error("frame still open after its result");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !res_valid)
    else $error("result given while no frame is armed");

  a_error_values_clear: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |-> (res.first_value == 8'd0 &&
                                            res.second_value == 32'd0))
    else $error("error result carries data values");

  a_data_index_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> (byte_index < data_count && data_count <= 8'(MAX_DATA)))
    else $error("data index beyond header count");

endmodule

>>> src/modbus_rtu_response_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus-RTU response receiver
// Checks one response frame after an arm word and reports status and data.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Contents
//  s_*       in         s_tvalid/s_tready   tuser kind, tdata received byte
//  m_*       out        m_tvalid/m_tready   tuser status, tdata count/values
//  cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// One input word is taken every cycle while s_tready is high; its result,
// if any, is in the output buffer on the next cycle. A two-word output buffer
// (register plus skid) lets input flow while a result waits; s_tready drops
// only when both are full. Reset clears the frame state and restores the
// register defaults; configuration writes are always taken.
// ----------------------------------------------------------------------------
module modbus_rtu_response_receiver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
  input  logic [1:0]                        s_tuser,   // [1:0] mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] byte_count, [15:8] first_value, [47:16] second_value
  output logic [mrr_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [2:0]                        m_tuser,   // [2:0] status
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mrr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mrr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mrr_pkg::*;

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res;

  result_t out_res, skid_res;
  logic    out_valid, skid_valid;
  logic    pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;
  assign pop       = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address   <= SLAVE_ADDRESS_RST;
      cfg.echo_mode       <= 1'b0;
      cfg.timeout_ticks   <= TIMEOUT_TICKS_RST;
      cfg.expected_length <= EXPECTED_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLAVE_ADDRESS:   cfg.slave_address   <= cfg_data[7:0];
        REG_ECHO_MODE:       cfg.echo_mode       <= cfg_data[0];
        REG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= cfg_data[15:0];
        REG_EXPECTED_LENGTH: cfg.expected_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mrr_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_accept),
    .mode     (s_tuser),
    .rx_byte  (s_tdata),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res)
  );

  // Input is held off while the skid word is full, so a new result never
  // meets a full buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || pop) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.second_value, out_res.first_value, out_res.byte_count};
  assign m_tuser  = out_res.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> m_tvalid)
    else $error("result lost on its way to the output");

endmodule
